>>> design/dsi_pkg.sv
// Package for the damped spring integrator: item structs, mode codes,
// configuration register indexes and fixed-point widths.
// No dependencies.
package dsi_pkg;

    // Fixed-point layout, signed Q16.16
    localparam int QW        = 32;
    localparam int CoefW     = 31;
    localparam int FracBits  = 16;
    localparam int CfgIdxW   = 8;
    localparam int CfgDataW  = 32;

    // Item modes
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_SET_TGT = 3'd1;
    localparam logic [2:0] MODE_SET_POS = 3'd2;
    localparam logic [2:0] MODE_SET_VEL = 3'd3;
    localparam logic [2:0] MODE_SNAP    = 3'd4;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_STIFFNESS = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_DAMPING   = 8'd1;
    localparam logic [CfgIdxW-1:0] CFG_MASS      = 8'd2;
    localparam logic [CfgIdxW-1:0] CFG_REST_THR  = 8'd3;

    localparam logic [CoefW-1:0] MassReset = 31'd65536;

    typedef struct packed {
        logic [2:0]              mode;
        logic [CoefW-1:0]        delta_time;
        logic signed [QW-1:0]    new_setting;
    } cmd_item_t;

    typedef struct packed {
        logic signed [QW-1:0]    position;
        logic signed [QW-1:0]    speed;
        logic                    settled;
    } res_item_t;

endpackage

>>> design/damped_spring_integrator.sv
// Top level of the damped spring integrator: state registers, sequencer,
// shared multiplier and serial divider. Depends on dsi_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  cmd     | in        | cmd_valid/cmd_ready  | cmd_item_t (mode, dt, value)
//  res     | out       | res_valid/res_ready  | res_item_t (pos, speed, flag)
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A setter, snap, unused mode or tick on a settled spring goes straight from idle
// to the final step. A tick on an unsettled spring runs the 64-step
// restoring divider for force / mass plus 12 sequencer steps around it.
// Reset clears target, position, velocity and the settled flag, and loads
// the register defaults. A stalled result holds in the output register;
// the next item is taken meanwhile and waits in the final step if needed.
module damped_spring_integrator
    import dsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_item_t            cmd,
    output logic                 res_valid,
    input  logic                 res_ready,
    output res_item_t            res,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    localparam int DivSteps = 64;
    localparam int CntW     = $clog2(DivSteps);
    localparam int ProdW    = 2 * QW;
    localparam int MulW     = QW + 1;
    localparam int ScW      = ProdW - FracBits;
    localparam int SumW     = ScW + 1;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_MK     = 14'b00000000000010,
        S_MC     = 14'b00000000000100,
        S_FORCE  = 14'b00000000001000,
        S_DINIT  = 14'b00000000010000,
        S_DIV    = 14'b00000000100000,
        S_ACC    = 14'b00000001000000,
        S_MA     = 14'b00000010000000,
        S_VEL    = 14'b00000100000000,
        S_MV     = 14'b00001000000000,
        S_POS    = 14'b00010000000000,
        S_SETTLE = 14'b00100000000000,
        S_FIN    = 14'b01000000000000,
        S_SPARE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CoefW-1:0]        stiff_reg, damp_reg, mass_reg, thr_reg;
    logic signed [QW-1:0]    tgt_reg, tgt_next;
    logic signed [QW-1:0]    pos_reg, pos_next;
    logic signed [QW-1:0]    vel_reg, vel_next;
    logic                    rest_reg, rest_next;
    logic [CoefW-1:0]        dt_reg, dt_next;
    logic signed [ProdW-1:0] prod_reg, prod_next;
    logic signed [ProdW-1:0] force_reg, force_next;
    logic [ProdW-1:0]        quo_reg, quo_next;
    logic [QW-1:0]           rem_reg, rem_next;
    logic [CntW-1:0]         cnt_reg, cnt_next;
    logic signed [QW-1:0]    accel_reg, accel_next;
    res_item_t               res_reg, res_next;
    logic                    res_valid_reg, res_valid_next;

    logic signed [MulW-1:0]  mul_a, mul_b;
    logic signed [2*MulW-1:0] mul_full;
    logic signed [QW:0]      disp_wide;
    logic signed [QW-1:0]    disp_sat;
    logic [QW:0]             dist_mag, vel_mag;
    logic                    round_up;
    logic signed [ScW-1:0]   scaled;
    logic signed [SumW-1:0]  vel_sum, pos_sum;
    logic [QW-1:0]           trial;
    logic                    trial_ge;
    logic signed [QW-1:0]    accel_val;
    logic                    res_free;
    logic                    cmd_take;

    // Saturate a wide signed sum to 32 bits
    function automatic logic signed [QW-1:0] sat_sum(input logic signed [SumW-1:0] v);
        logic signed [QW-1:0] r;
        if (v > $signed({{(SumW-QW){1'b0}}, {1'b0, {(QW-1){1'b1}}}}))
            r = {1'b0, {(QW-1){1'b1}}};
        else if (v < $signed({{(SumW-QW){1'b1}}, {1'b1, {(QW-1){1'b0}}}}))
            r = {1'b1, {(QW-1){1'b0}}};
        else
            r = v[QW-1:0];
        return r;
    endfunction

    assign cmd_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign cmd_take  = cmd_valid && cmd_ready;
    assign res_free  = !res_valid_reg || res_ready;

    // Displacement, exact and saturated
    assign disp_wide = $signed({pos_reg[QW-1], pos_reg}) - $signed({tgt_reg[QW-1], tgt_reg});
    always_comb
    begin
        if (disp_wide[QW] != disp_wide[QW-1])
            disp_sat = disp_wide[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        else
            disp_sat = disp_wide[QW-1:0];
    end
    assign dist_mag = disp_wide[QW] ? (QW+1)'(-disp_wide) : disp_wide;
    assign vel_mag  = vel_reg[QW-1] ? (QW+1)'(-$signed({vel_reg[QW-1], vel_reg}))
                                    : {1'b0, vel_reg};

    // Select operands of the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_MK:
            begin
                mul_a = $signed({2'b00, stiff_reg});
                mul_b = $signed({disp_sat[QW-1], disp_sat});
            end
            S_MC:
            begin
                mul_a = $signed({2'b00, damp_reg});
                mul_b = $signed({vel_reg[QW-1], vel_reg});
            end
            S_MA:
            begin
                mul_a = $signed({accel_reg[QW-1], accel_reg});
                mul_b = $signed({2'b00, dt_reg});
            end
            default:
            begin
                mul_a = $signed({vel_reg[QW-1], vel_reg});
                mul_b = $signed({2'b00, dt_reg});
            end
        endcase
    end
    assign mul_full = mul_a * mul_b;

    // Divide the product by 2^16, toward zero
    assign round_up = prod_reg[ProdW-1] && (prod_reg[FracBits-1:0] != '0);
    assign scaled   = prod_reg[ProdW-1:FracBits] + $signed({{(ScW-1){1'b0}}, round_up});
    assign vel_sum  = $signed({{(SumW-QW){vel_reg[QW-1]}}, vel_reg})
                    + $signed({scaled[ScW-1], scaled});
    assign pos_sum  = $signed({{(SumW-QW){pos_reg[QW-1]}}, pos_reg})
                    + $signed({scaled[ScW-1], scaled});

    // One restoring divider step
    assign trial    = {rem_reg[QW-2:0], quo_reg[ProdW-1]};
    assign trial_ge = trial >= {1'b0, mass_reg};

    // Turn the quotient magnitude into a saturated acceleration
    always_comb
    begin
        if (mass_reg == '0)
        begin
            if (force_reg > 0)
                accel_val = {1'b0, {(QW-1){1'b1}}};
            else if (force_reg < 0)
                accel_val = {1'b1, {(QW-1){1'b0}}};
            else
                accel_val = '0;
        end
        else if (force_reg[ProdW-1])
        begin
            if ((quo_reg[ProdW-1:QW] != '0) || (quo_reg[QW-1] && (quo_reg[QW-2:0] != '0)))
                accel_val = {1'b1, {(QW-1){1'b0}}};
            else
                accel_val = -$signed(quo_reg[QW-1:0]);
        end
        else
        begin
            if (quo_reg[ProdW-1:QW-1] != '0)
                accel_val = {1'b0, {(QW-1){1'b1}}};
            else
                accel_val = $signed(quo_reg[QW-1:0]);
        end
    end

    // Sequencer and state updates
    always_comb
    begin
        state_next     = state_reg;
        tgt_next       = tgt_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        rest_next      = rest_reg;
        dt_next        = dt_reg;
        prod_next      = prod_reg;
        force_next     = force_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        accel_next     = accel_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    dt_next    = cmd.delta_time;
                    state_next = S_FIN;
                    case (cmd.mode)
                        MODE_TICK:
                        begin
                            if (!rest_reg)
                                state_next = S_MK;
                        end
                        MODE_SET_TGT:
                        begin
                            tgt_next  = cmd.new_setting;
                            rest_next = 1'b0;
                        end
                        MODE_SET_POS:
                        begin
                            pos_next  = cmd.new_setting;
                            rest_next = 1'b0;
                        end
                        MODE_SET_VEL:
                        begin
                            vel_next  = cmd.new_setting;
                            rest_next = 1'b0;
                        end
                        MODE_SNAP:
                        begin
                            pos_next  = tgt_reg;
                            vel_next  = '0;
                            rest_next = 1'b1;
                        end
                        default:
                        begin
                            rest_next = rest_reg;
                        end
                    endcase
                end
            end
            S_MK:
            begin
                prod_next  = mul_full[ProdW-1:0];
                state_next = S_MC;
            end
            S_MC:
            begin
                force_next = -prod_reg;
                prod_next  = mul_full[ProdW-1:0];
                state_next = S_FORCE;
            end
            S_FORCE:
            begin
                force_next = force_reg - prod_reg;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                quo_next   = force_reg[ProdW-1] ? ProdW'(-force_reg) : force_reg;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = trial_ge ? (trial - {1'b0, mass_reg}) : trial;
                quo_next = {quo_reg[ProdW-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DivSteps - 1))
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                accel_next = accel_val;
                state_next = S_MA;
            end
            S_MA:
            begin
                prod_next  = mul_full[ProdW-1:0];
                state_next = S_VEL;
            end
            S_VEL:
            begin
                vel_next   = sat_sum(vel_sum);
                state_next = S_MV;
            end
            S_MV:
            begin
                prod_next  = mul_full[ProdW-1:0];
                state_next = S_POS;
            end
            S_POS:
            begin
                pos_next   = sat_sum(pos_sum);
                state_next = S_SETTLE;
            end
            S_SETTLE:
            begin
                if ((vel_mag < {2'b00, thr_reg}) && (dist_mag < {2'b00, thr_reg}))
                begin
                    pos_next  = tgt_reg;
                    vel_next  = '0;
                    rest_next = 1'b1;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (res_free)
                begin
                    res_next.position = pos_reg;
                    res_next.speed    = vel_reg;
                    res_next.settled  = rest_reg;
                    res_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            tgt_reg       <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            rest_reg      <= 1'b0;
            stiff_reg     <= '0;
            damp_reg      <= '0;
            mass_reg      <= MassReset;
            thr_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            tgt_reg       <= tgt_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            rest_reg      <= rest_next;
            cnt_reg       <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_STIFFNESS: stiff_reg <= cfg_data[CoefW-1:0];
                    CFG_DAMPING:   damp_reg  <= cfg_data[CoefW-1:0];
                    CFG_MASS:      mass_reg  <= cfg_data[CoefW-1:0];
                    CFG_REST_THR:  thr_reg   <= cfg_data[CoefW-1:0];
                    default:       thr_reg   <= thr_reg;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dt_reg    <= dt_next;
        prod_reg  <= prod_next;
        force_reg <= force_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        accel_reg <= accel_next;
        res_reg   <= res_next;
    end

endmodule

>>> design/dsi_checker.sv
// Port-level checker for the damped spring integrator, bound to the top level.
// Depends on dsi_pkg and damped_spring_integrator.
module dsi_port_checker
    import dsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic                 cmd_ready,
    input  cmd_item_t            cmd,
    input  logic                 res_valid,
    input  logic                 res_ready,
    input  res_item_t            res,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("stalled result changed");

    // Drop ready once an item is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("item taken while busy");

    // A settled spring reports zero speed
    a_settled: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.settled |-> res.speed == '0)
        else $error("settled result with nonzero speed");

    // Accept every register write
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind damped_spring_integrator dsi_port_checker u_dsi_port_checker (.*);
